FILE: hdl/etf_pkg.sv
// ----------------------------------------------------------------------------
// etf_pkg
// Shared types and constants for the escape-time fractal iterator.
// ----------------------------------------------------------------------------
package etf_pkg;

  typedef logic [1:0] kind_t;
  typedef logic       cfg_idx_t;

  localparam kind_t KIND_MANDELBROT   = 2'd0;
  localparam kind_t KIND_BURNING_SHIP = 2'd1;
  localparam kind_t KIND_TRICORN      = 2'd2;

  localparam cfg_idx_t CFG_IDX_KIND  = 1'b0;
  localparam cfg_idx_t CFG_IDX_LIMIT = 1'b1;

  localparam kind_t       KIND_RESET  = KIND_MANDELBROT;
  localparam int unsigned LIMIT_RESET = 400;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

endpackage

FILE: hdl/escape_time_fractal_iterator.sv
// ----------------------------------------------------------------------------
// escape_time_fractal_iterator
// Escape-time iteration of one complex point per beat (Mandelbrot family).
// ----------------------------------------------------------------------------
// Each input beat carries a point c in signed fixed point (COORD_WIDTH bits,
// FRAC_BITS fraction bits). The orbit starts at z = c and steps z <- f(z) + c
// until |z|^2 >= 4 or the count reaches iteration_limit; the result beat gives
// the count and whether the limit was hit. Every iteration passes through the
// multiply state, with its three multipliers, and then the update state, which
// holds the update and the escape compare.
// A two-entry queue takes new points while the core works, and a result
// register holds a finished beat while the core moves on. Write configuration
// only while no point is in flight.
module escape_time_fractal_iterator #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  etf_pkg::cfg_idx_t             cfg_index,
  input  logic [COUNT_WIDTH-1:0]        cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_c_real,
  input  logic signed [COORD_WIDTH-1:0] in_c_imag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COUNT_WIDTH-1:0]        out_iteration_count,
  output logic                          out_hit_limit
);
  import etf_pkg::*;

  kind_t                   kind_r;
  logic [COUNT_WIDTH-1:0]  limit_r;
  logic                    q_valid, q_pop;
  logic signed [COORD_WIDTH-1:0] q_c_real, q_c_imag;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_RESET;
      limit_r <= COUNT_WIDTH'(LIMIT_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_KIND:  kind_r  <= cfg_data[1:0];
        CFG_IDX_LIMIT: limit_r <= cfg_data;
        default: ;
      endcase
    end
  end

  etf_front #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_c_real(in_c_real),
    .in_c_imag(in_c_imag),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_c_real (q_c_real),
    .q_c_imag (q_c_imag)
  );

  etf_core #(
    .COORD_WIDTH(COORD_WIDTH),
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .kind               (kind_r),
    .limit              (limit_r),
    .q_valid            (q_valid),
    .q_pop              (q_pop),
    .q_c_real           (q_c_real),
    .q_c_imag           (q_c_imag),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_iteration_count(out_iteration_count),
    .out_hit_limit      (out_hit_limit)
  );

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("result or queue not cleared by reset");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("core took a point from an empty queue");

  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> q_valid)
    else $error("input stalled while queue holds nothing");

endmodule

FILE: hdl/etf_front.sv
// ----------------------------------------------------------------------------
// etf_front
// Input side: accepts points and holds them in a short queue for the core.
// ----------------------------------------------------------------------------
module etf_front #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [COORD_WIDTH-1:0] in_c_real,
  input  logic signed [COORD_WIDTH-1:0] in_c_imag,
  output logic                          q_valid,
  input  logic                          q_pop,
  output logic signed [COORD_WIDTH-1:0] q_c_real,
  output logic signed [COORD_WIDTH-1:0] q_c_imag
);
  import etf_pkg::*;

  localparam int EW = 2 * COORD_WIDTH;

  logic [EW-1:0]     ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;

  assign in_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid  = (cnt_r != '0);
  assign push     = in_valid && in_ready;
  assign q_c_real = ent_r[rd_ptr_r][EW-1:COORD_WIDTH];
  assign q_c_imag = ent_r[rd_ptr_r][COORD_WIDTH-1:0];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= {in_c_real, in_c_imag};
    end
  end

endmodule

FILE: hdl/etf_core.sv
// ----------------------------------------------------------------------------
// etf_core
// Orbit engine: multiply stage and update stage per iteration, result register.
// ----------------------------------------------------------------------------
module etf_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 28,
  parameter int COUNT_WIDTH = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  etf_pkg::kind_t                kind,
  input  logic [COUNT_WIDTH-1:0]        limit,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic signed [COORD_WIDTH-1:0] q_c_real,
  input  logic signed [COORD_WIDTH-1:0] q_c_imag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COUNT_WIDTH-1:0]        out_iteration_count,
  output logic                          out_hit_limit
);
  import etf_pkg::*;

  localparam int W   = COORD_WIDTH;
  localparam int PW  = 2 * W;
  localparam int EW  = 2 * W + 2;
  localparam int E4  = 2 * FRAC_BITS + 2;
  localparam bit FOUR_FITS = (E4 < EW);
  localparam logic [EW-1:0] FOUR = FOUR_FITS ? (EW'(1) << E4) : '0;
  localparam logic signed [EW-1:0] MAXV = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [EW-1:0] MINV = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_UPD  = 2'd2;
  localparam logic [1:0] S_RES  = 2'd3;

  function automatic logic signed [W-1:0] sat(input logic signed [EW-1:0] v);
    logic signed [W-1:0] r;
    if (v > MAXV) begin
      r = MAXV[W-1:0];
    end else if (v < MINV) begin
      r = MINV[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  logic [1:0]             state_r, state_nxt;
  logic signed [W-1:0]    zr_r, zi_r, cr_r, ci_r;
  logic signed [PW-1:0]   xx_r, yy_r, xy_r;
  logic [COUNT_WIDTH-1:0] n_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [COUNT_WIDTH-1:0] out_count_r;
  logic                   out_hit_r;

  logic signed [EW-1:0]   xx_e, yy_e, xy_e, xy_sel;
  logic [EW-1:0]          mag2;
  logic                   escaped, finish, hit, out_load, out_free;
  logic signed [EW-1:0]   re_sum, im_sum;
  logic signed [W-1:0]    zr_new, zi_new;

  assign xx_e    = EW'(xx_r);
  assign yy_e    = EW'(yy_r);
  assign xy_e    = EW'(xy_r);
  assign mag2    = xx_e + yy_e;
  assign escaped = FOUR_FITS && (mag2 >= FOUR);
  assign finish  = (n_r >= limit) || escaped;
  assign hit     = (n_r == limit);

  always_comb begin
    if (kind == KIND_TRICORN || (kind == KIND_BURNING_SHIP && xy_r[PW-1])) begin
      xy_sel = -xy_e;
    end else begin
      xy_sel = xy_e;
    end
  end

  assign re_sum = ((xx_e - yy_e) >>> FRAC_BITS) + EW'(cr_r);
  assign im_sum = (xy_sel >>> (FRAC_BITS - 1)) + EW'(ci_r);
  assign zr_new = sat(re_sum);
  assign zi_new = sat(im_sum);

  assign out_free = !out_valid_r || out_ready;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!finish) begin
          state_nxt = S_MUL;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      zr_r <= q_c_real;
      zi_r <= q_c_imag;
      cr_r <= q_c_real;
      ci_r <= q_c_imag;
      n_r  <= '0;
    end else if (state_r == S_UPD && !finish) begin
      zr_r <= zr_new;
      zi_r <= zi_new;
      n_r  <= n_r + 1'b1;
    end
    if (state_r == S_MUL) begin
      xx_r <= zr_r * zr_r;
      yy_r <= zi_r * zi_r;
      xy_r <= zr_r * zi_r;
    end
    if (out_load) begin
      out_count_r <= n_r;
      out_hit_r   <= hit;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_hit_limit       = out_hit_r;

endmodule

FILE: tb/tb_escape_time_fractal_iterator.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_escape_time_fractal_iterator
// Self-checking bench for the escape-time fractal iterator.
// ----------------------------------------------------------------------------
// A table of directed points runs first: the reset settings, the coordinate
// extremes, points that escape at once, every fractal kind including the
// unused code, and the zero, one and largest iteration limits. Random phases
// follow, each with its own kind and limit; most points lie in the region
// where orbits stay bounded for a while. Each result beat is compared with its
// typed table row, or else with a bit-exact escape-time predictor in the bench.
// ----------------------------------------------------------------------------
module tb_escape_time_fractal_iterator;
  import etf_pkg::*;

  localparam int FRAC         = 28;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_ITEMS  = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int N_DIRECTED   = 22;
  localparam longint TIMEOUT_NS = 200_000_000;

  localparam kind_t KIND_UNUSED = 2'd3;

  localparam logic signed [31:0] C_ZERO    = 32'sh0000_0000;
  localparam logic signed [31:0] C_ONE     = 32'sh1000_0000;
  localparam logic signed [31:0] C_TWO     = 32'sh2000_0000;
  localparam logic signed [31:0] C_THREE   = 32'sh3000_0000;
  localparam logic signed [31:0] C_QUARTER = 32'sh0400_0000;
  localparam logic signed [31:0] C_NEG_ONE = 32'shF000_0000;
  localparam logic signed [31:0] C_NEG_TWO = 32'shE000_0000;
  localparam logic signed [31:0] C_HALF_N  = 32'shF800_0000;
  localparam logic signed [31:0] C_HALF    = 32'sh0800_0000;
  localparam logic signed [31:0] C_MAX     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] C_MIN     = 32'sh8000_0000;
  localparam logic signed [31:0] C_SPAN    = 32'sh2400_0000;

  localparam logic signed [127:0] WIDE_MAX  = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] WIDE_MIN  = -WIDE_MAX - 128'sd1;
  localparam logic signed [127:0] FOUR_WIDE = 128'sd1 <<< (2 * FRAC + 2);

  typedef struct packed {
    logic [9:0] count;
    logic       hit;
  } escape_result_t;

  typedef struct {
    kind_t             kind;
    logic [9:0]        lim;
    logic signed [31:0] cr;
    logic signed [31:0] ci;
    bit                typed;
    logic [9:0]        cnt;
    bit                hit;
  } point_row_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_idx_t           cfg_index;
  logic [9:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_c_real;
  logic signed [31:0] in_c_imag;
  logic               out_valid;
  logic               out_ready;
  logic [9:0]         out_iteration_count;
  logic               out_hit_limit;

  // expectation typed into the table, carried along with the beat
  logic               beat_typed;
  logic [9:0]         beat_count;
  logic               beat_hit;

  escape_result_t expected_counts[$];
  kind_t          iter_kind;
  logic [9:0]     iter_limit;
  int unsigned    fail_count;
  int unsigned    points_sent;
  int unsigned    results_seen;
  int unsigned    settings_used;
  bit             quiet;
  bit             hold_req;

  point_row_t directed [N_DIRECTED] = '{
    '{KIND_MANDELBROT,   10'd400,  C_ZERO,    C_ZERO,    1'b1, 10'd400,  1'b1},
    '{KIND_MANDELBROT,   10'd400,  C_TWO,     C_ZERO,    1'b1, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  C_MAX,     C_MAX,     1'b1, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  C_MIN,     C_MIN,     1'b1, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  C_MIN,     C_ZERO,    1'b1, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  C_ZERO,    C_MAX,     1'b1, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  C_NEG_TWO, C_ZERO,    1'b1, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  C_NEG_ONE, C_ZERO,    1'b1, 10'd400,  1'b1},
    '{KIND_MANDELBROT,   10'd400,  C_ONE,     C_ZERO,    1'b1, 10'd1,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  C_QUARTER, C_ZERO,    1'b0, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  C_ZERO,    C_ONE,     1'b0, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd400,  32'sd1,    -32'sd1,   1'b0, 10'd0,    1'b0},
    '{KIND_BURNING_SHIP, 10'd64,   32'shE400_0000, 32'shFF00_0000, 1'b0, 10'd0, 1'b0},
    '{KIND_BURNING_SHIP, 10'd64,   C_HALF_N,  C_HALF_N,  1'b0, 10'd0,    1'b0},
    '{KIND_TRICORN,      10'd64,   C_ZERO,    C_ONE,     1'b0, 10'd0,    1'b0},
    '{KIND_TRICORN,      10'd64,   C_HALF_N,  C_HALF,    1'b0, 10'd0,    1'b0},
    '{KIND_UNUSED,       10'd64,   C_NEG_ONE, C_ZERO,    1'b0, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd0,    C_ZERO,    C_ZERO,    1'b1, 10'd0,    1'b1},
    '{KIND_MANDELBROT,   10'd0,    C_MAX,     C_MAX,     1'b1, 10'd0,    1'b1},
    '{KIND_MANDELBROT,   10'd1,    C_ZERO,    C_ZERO,    1'b1, 10'd1,    1'b1},
    '{KIND_MANDELBROT,   10'd1,    C_THREE,   C_ZERO,    1'b1, 10'd0,    1'b0},
    '{KIND_MANDELBROT,   10'd1023, C_ZERO,    C_ZERO,    1'b1, 10'd1023, 1'b1}
  };

  escape_time_fractal_iterator uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_c_real           (in_c_real),
    .in_c_imag           (in_c_imag),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_iteration_count (out_iteration_count),
    .out_hit_limit       (out_hit_limit)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic signed [31:0] clamp_coord(input logic signed [127:0] v);
    if (v > WIDE_MAX)
      return WIDE_MAX[31:0];
    if (v < WIDE_MIN)
      return WIDE_MIN[31:0];
    return v[31:0];
  endfunction

  function automatic escape_result_t escape_count(input logic signed [31:0] cr,
                                                  input logic signed [31:0] ci,
                                                  input kind_t kind,
                                                  input logic [9:0] limit);
    logic signed [127:0] cx, cy, zx, zy, xx, yy, xy;
    int unsigned n;
    escape_result_t r;
    cx = cr;
    cy = ci;
    zx = cx;
    zy = cy;
    n  = 0;
    while (n < limit) begin
      xx = zx * zx;
      yy = zy * zy;
      if (xx + yy >= FOUR_WIDE)
        break;
      xy = zx * zy;
      if (kind == KIND_BURNING_SHIP && xy < 0)
        xy = -xy;
      else if (kind == KIND_TRICORN)
        xy = -xy;
      zx = clamp_coord(((xx - yy) >>> FRAC) + cx);
      zy = clamp_coord((xy >>> (FRAC - 1)) + cy);
      n++;
    end
    r.count = 10'(n);
    r.hit   = (n == limit);
    return r;
  endfunction

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return C_MAX;
          1: return C_MIN;
          2: return C_ZERO;
          3: return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default: return $signed($urandom_range(0, 2 * C_SPAN)) - C_SPAN;
    endcase
  endfunction

  // scoreboard: queue an expectation for every accepted point, check every result beat
  always @(posedge clk) begin : scoreboard
    escape_result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (beat_typed)
          want = '{count: beat_count, hit: beat_hit};
        else
          want = escape_count(in_c_real, in_c_imag, iter_kind, iter_limit);
        expected_counts.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_counts.size() == 0) begin
          $error("result beat with nothing expected: count %0d hit %0b",
                 out_iteration_count, out_hit_limit);
          fail_count++;
        end else begin
          want = expected_counts.pop_front();
          if (out_iteration_count !== want.count) begin
            $error("iteration_count: expected %0d, actual %0d", want.count,
                   out_iteration_count);
            fail_count++;
          end
          if (out_hit_limit !== want.hit) begin
            $error("hit_limit: expected %0b, actual %0b", want.hit, out_hit_limit);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_IDX_KIND:  iter_kind  = kind_t'(cfg_data[1:0]);
          CFG_IDX_LIMIT: iter_limit = cfg_data;
          default: ;
        endcase
      end
    end
  end

  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        out_ready  <= 1'b0;
        stall_left = HOLD_CYCLES - 1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready  <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_point(input logic signed [31:0] cr, input logic signed [31:0] ci,
                            input bit typed, input logic [9:0] cnt, input bit hit);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_c_real  <= cr;
    in_c_imag  <= ci;
    beat_typed <= typed;
    beat_count <= cnt;
    beat_hit   <= hit;
    do @(posedge clk); while (!(in_valid && in_ready));
    points_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [9:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
  endtask

  task automatic set_config(input kind_t k, input logic [9:0] lim, input bit garble);
    write_reg(CFG_IDX_KIND, garble ? {8'($urandom_range(0, 255)), k} : {8'd0, k});
    write_reg(CFG_IDX_LIMIT, lim);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin : stimulus
    int unsigned phase, items, random_sent;
    kind_t       cur_kind;
    logic [9:0]  cur_lim;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = CFG_IDX_KIND;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_c_real   = '0;
    in_c_imag   = '0;
    beat_typed  = 1'b0;
    beat_count  = '0;
    beat_hit    = 1'b0;
    iter_kind   = KIND_RESET;
    iter_limit  = 10'(LIMIT_RESET);
    fail_count  = 0;
    points_sent = 0;
    results_seen  = 0;
    settings_used = 1;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    cur_kind    = KIND_RESET;
    cur_lim     = 10'(LIMIT_RESET);
    random_sent = 0;
    phase       = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      if (directed[i].kind != cur_kind || directed[i].lim != cur_lim) begin
        wait_drained();
        cur_kind = directed[i].kind;
        cur_lim  = directed[i].lim;
        set_config(cur_kind, cur_lim, 1'b0);
      end
      send_point(directed[i].cr, directed[i].ci, directed[i].typed,
                 directed[i].cnt, directed[i].hit);
    end

    while (random_sent < RANDOM_ITEMS) begin
      cur_kind = kind_t'($urandom_range(0, 3));
      case (phase)
        0: cur_lim = 10'd1023;
        1: cur_lim = 10'd1;
        2: cur_lim = 10'd8;
        default: begin
          case ($urandom_range(0, 9))
            0: cur_lim = 10'd1023;
            1: cur_lim = 10'd1;
            2: cur_lim = 10'($urandom_range(200, 600));
            default: cur_lim = 10'($urandom_range(2, 40));
          endcase
        end
      endcase
      items = (cur_lim > 100) ? $urandom_range(4, 10) : $urandom_range(30, 80);
      wait_drained();
      set_config(cur_kind, cur_lim, $urandom_range(0, 1));
      // hold the result side off while points keep coming
      if (phase == 2)
        hold_req = 1'b1;
      for (int i = 0; i < items; i++) begin
        if (random_sent >= RANDOM_ITEMS - QUIET_ITEMS)
          quiet = 1'b1;
        if (phase == 3 && i == items / 2)
          wait_drained();
        send_point(pick_coord(), pick_coord(), 1'b0, '0, 1'b0);
        random_sent++;
      end
      phase++;
    end

    wait_drained();
    repeat (2 * cur_lim + 8) @(posedge clk);
    if (expected_counts.size() != 0) begin
      $error("%0d expected results never arrived", expected_counts.size());
      fail_count++;
    end
    $display("Run covered %0d points (%0d from the table) over %0d register settings,",
             points_sent, N_DIRECTED, settings_used);
    $display("all four kind codes and limits from 0 to 1023; %0d result beats checked.",
             results_seen);
    if (fail_count == 0)
      $display("** escape_time_fractal_iterator: PASSED **");
    else
      $display("** escape_time_fractal_iterator: FAILED **");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("** escape_time_fractal_iterator: FAILED **");
    $finish;
  end

endmodule

FILE: sim.f
hdl/etf_pkg.sv
hdl/etf_front.sv
hdl/etf_core.sv
hdl/escape_time_fractal_iterator.sv
tb/tb_escape_time_fractal_iterator.sv
